// ===== hdl/pol_pkg.sv =====
// ----------------------------------------------------------------------------
// pol_pkg
// Types, codes and sizes shared by the positional ordered list block.
// ----------------------------------------------------------------------------
package pol_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // Fixed field widths of the channels
  localparam int CMD_W       = 3;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 6;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;
  localparam int ELEM_OUT_W  = 32;

  // Internal sizes
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_DUMP      = 3'd6
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    DP_NOP,
    DP_INS,
    DP_DEL
  } dp_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic             capture;
    dp_op_e           op;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] rd_idx;
    logic             load_res;
    status_e          res_status;
    logic             res_elem;
    logic             res_last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             res_busy;
  } dp_stat_t;

endpackage

// ===== hdl/pol_cmd_if.sv =====
// ----------------------------------------------------------------------------
// pol_cmd_if
// Command channel: valid/ready handshake with command, value and position.
// ----------------------------------------------------------------------------
interface pol_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [pol_pkg::CMD_W-1:0]   command;
  logic [pol_pkg::VALUE_W-1:0] value;
  logic [pol_pkg::POS_W-1:0]   position;

  modport source (output valid, output command, output value, output position,
                  input ready);
  modport sink   (input valid, input command, input value, input position,
                  output ready);
endinterface

// ===== hdl/pol_res_if.sv =====
// ----------------------------------------------------------------------------
// pol_res_if
// Result channel: valid/ready handshake with status, count and dump element.
// ----------------------------------------------------------------------------
interface pol_res_if;
  logic                          valid;
  logic                          ready;
  logic [pol_pkg::STATUS_W-1:0]    status;
  logic [pol_pkg::COUNT_OUT_W-1:0] entry_count;
  logic [pol_pkg::ELEM_OUT_W-1:0]  element;
  logic                          element_valid;
  logic                          last;

  modport source (output valid, output status, output entry_count, output element,
                  output element_valid, output last, input ready);
  modport sink   (input valid, input status, input entry_count, input element,
                  input element_valid, input last, output ready);
endinterface

// ===== hdl/pol_datapath.sv =====
// ----------------------------------------------------------------------------
// pol_datapath
// Entry register file with positional shift, entry count and
// result output register.
// ----------------------------------------------------------------------------
module pol_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pol_pkg::dp_cmd_t                 cmd_i,
  output pol_pkg::dp_stat_t                stat_o,
  input  logic [pol_pkg::VALUE_W-1:0]      value_i,
  input  logic                             res_ready_i,
  output logic                             res_valid_o,
  output logic [pol_pkg::STATUS_W-1:0]     res_status_o,
  output logic [pol_pkg::COUNT_OUT_W-1:0]  res_count_o,
  output logic [pol_pkg::ELEM_OUT_W-1:0]   res_element_o,
  output logic                             res_elem_valid_o,
  output logic                             res_last_o
);

  logic [pol_pkg::DATA_WIDTH-1:0] entries_q [pol_pkg::CAPACITY];
  logic [pol_pkg::DATA_WIDTH-1:0] entries_d [pol_pkg::CAPACITY];
  logic [pol_pkg::DATA_WIDTH-1:0] value_q, value_d;
  logic [pol_pkg::CNT_W-1:0]      count_q, count_d;
  logic                           res_valid_q, res_valid_d;
  logic [pol_pkg::DATA_WIDTH-1:0] rd_data;

  // Each entry picks its own next value: hold, take the word, or shift
  for (genvar j = 0; j < pol_pkg::CAPACITY; j++) begin : g_entry
    logic [pol_pkg::DATA_WIDTH-1:0] lower_nb;
    logic [pol_pkg::DATA_WIDTH-1:0] upper_nb;

    if (j == 0) begin : g_first
      assign lower_nb = entries_q[j];
    end else begin : g_rest
      assign lower_nb = entries_q[j-1];
    end

    if (j == pol_pkg::CAPACITY - 1) begin : g_top
      assign upper_nb = entries_q[j];
    end else begin : g_below
      assign upper_nb = entries_q[j+1];
    end

    always_comb begin
      entries_d[j] = entries_q[j];
      unique case (cmd_i.op)
        pol_pkg::DP_INS: begin
          if (pol_pkg::IDX_W'(j) == cmd_i.idx) begin
            entries_d[j] = value_q;
          end else if (pol_pkg::IDX_W'(j) > cmd_i.idx) begin
            entries_d[j] = lower_nb;
          end
        end
        pol_pkg::DP_DEL: begin
          if (pol_pkg::IDX_W'(j) >= cmd_i.idx) begin
            entries_d[j] = upper_nb;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entries_q <= entries_d;
  end

  always_comb begin
    value_d = cmd_i.capture ? pol_pkg::DATA_WIDTH'(value_i) : value_q;
    unique case (cmd_i.op)
      pol_pkg::DP_INS: count_d = count_q + pol_pkg::CNT_W'(1);
      pol_pkg::DP_DEL: count_d = count_q - pol_pkg::CNT_W'(1);
      default:         count_d = count_q;
    endcase
    if (cmd_i.load_res) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  assign rd_data = entries_q[cmd_i.rd_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    if (cmd_i.load_res) begin
      res_status_o     <= cmd_i.res_status;
      res_count_o      <= pol_pkg::COUNT_OUT_W'(count_d);
      res_element_o    <= cmd_i.res_elem ? pol_pkg::ELEM_OUT_W'(rd_data) : '0;
      res_elem_valid_o <= cmd_i.res_elem;
      res_last_o       <= cmd_i.res_last;
    end
  end

  assign res_valid_o     = res_valid_q;
  assign stat_o.count    = count_q;
  assign stat_o.res_busy = res_valid_q & ~res_ready_i;

endmodule

// ===== hdl/pol_ctrl.sv =====
// ----------------------------------------------------------------------------
// pol_ctrl
// Command sequencer: takes a transaction, checks it against the count and
// steers the datapath; walks the entries one result at a time on dump.
// ----------------------------------------------------------------------------
module pol_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  logic [pol_pkg::CMD_W-1:0]   cmd_command_i,
  input  logic [pol_pkg::POS_W-1:0]   cmd_position_i,
  input  pol_pkg::dp_stat_t           stat_i,
  output pol_pkg::dp_cmd_t            dp_o
);

  pol_pkg::ctrl_state_e       state_q, state_d;
  pol_pkg::cmd_e              op_q, op_d;
  logic [pol_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [pol_pkg::IDX_W-1:0]  dump_idx_q, dump_idx_d;

  logic [pol_pkg::CMP_W-1:0]  pos_ext, cnt_ext;
  logic                       full, empty, dump_last;

  assign pos_ext   = pol_pkg::CMP_W'(pos_q);
  assign cnt_ext   = pol_pkg::CMP_W'(stat_i.count);
  assign full      = (stat_i.count == pol_pkg::CNT_W'(pol_pkg::CAPACITY));
  assign empty     = (stat_i.count == '0);
  assign dump_last = ((pol_pkg::CNT_W'(dump_idx_q) + pol_pkg::CNT_W'(1)) == stat_i.count);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    pos_d      = pos_q;
    dump_idx_d = dump_idx_q;
    cmd_ready_o = 1'b0;

    dp_o            = '0;
    dp_o.op         = pol_pkg::DP_NOP;
    dp_o.res_status = pol_pkg::ST_OK;
    dp_o.rd_idx     = dump_idx_q;

    unique case (state_q)
      pol_pkg::S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          dp_o.capture = 1'b1;
          op_d         = pol_pkg::cmd_e'(cmd_command_i);
          pos_d        = cmd_position_i;
          state_d      = pol_pkg::S_EXEC;
        end
      end

      pol_pkg::S_EXEC: begin
        // wait for the result slot before changing anything
        if (!stat_i.res_busy) begin
          dp_o.load_res = 1'b1;
          dp_o.res_last = 1'b1;
          state_d       = pol_pkg::S_IDLE;
          unique case (op_q)
            pol_pkg::CMD_INS_FRONT, pol_pkg::CMD_INS_BACK: begin
              if (full) begin
                dp_o.res_status = pol_pkg::ST_FULL;
              end else begin
                dp_o.op  = pol_pkg::DP_INS;
                dp_o.idx = (op_q == pol_pkg::CMD_INS_FRONT) ?
                           '0 : pol_pkg::IDX_W'(stat_i.count);
              end
            end
            pol_pkg::CMD_INS_AT: begin
              if (pos_q == '0 || pos_ext > cnt_ext + pol_pkg::CMP_W'(1)) begin
                dp_o.res_status = pol_pkg::ST_BAD_POS;
              end else if (full) begin
                dp_o.res_status = pol_pkg::ST_FULL;
              end else begin
                dp_o.op  = pol_pkg::DP_INS;
                dp_o.idx = pol_pkg::IDX_W'(pos_ext - pol_pkg::CMP_W'(1));
              end
            end
            pol_pkg::CMD_DEL_FRONT, pol_pkg::CMD_DEL_BACK: begin
              if (empty) begin
                dp_o.res_status = pol_pkg::ST_EMPTY;
              end else begin
                dp_o.op  = pol_pkg::DP_DEL;
                dp_o.idx = (op_q == pol_pkg::CMD_DEL_FRONT) ?
                           '0 : pol_pkg::IDX_W'(stat_i.count - pol_pkg::CNT_W'(1));
              end
            end
            pol_pkg::CMD_DEL_AT: begin
              if (empty) begin
                dp_o.res_status = pol_pkg::ST_EMPTY;
              end else if (pos_q == '0 || pos_ext > cnt_ext) begin
                dp_o.res_status = pol_pkg::ST_BAD_POS;
              end else begin
                dp_o.op  = pol_pkg::DP_DEL;
                dp_o.idx = pol_pkg::IDX_W'(pos_ext - pol_pkg::CMP_W'(1));
              end
            end
            pol_pkg::CMD_DUMP: begin
              if (empty) begin
                dp_o.res_status = pol_pkg::ST_EMPTY;
              end else begin
                // no result here: the walk starts at the front in the dump state
                dp_o.load_res = 1'b0;
                dp_o.res_last = 1'b0;
                dump_idx_d    = '0;
                state_d       = pol_pkg::S_DUMP;
              end
            end
            default: ;  // unused code: plain ok result
          endcase
        end
      end

      pol_pkg::S_DUMP: begin
        if (!stat_i.res_busy) begin
          dp_o.load_res = 1'b1;
          dp_o.res_elem = 1'b1;
          dp_o.res_last = dump_last;
          if (dump_last) begin
            state_d = pol_pkg::S_IDLE;
          end else begin
            dump_idx_d = dump_idx_q + pol_pkg::IDX_W'(1);
          end
        end
      end

      default: state_d = pol_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pol_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    pos_q      <= pos_d;
    dump_idx_q <= dump_idx_d;
  end

endmodule

// ===== hdl/positional_ordered_list_top.sv =====
// ----------------------------------------------------------------------------
// positional_ordered_list_top
// Ordered list of up to CAPACITY words with positional insert, delete and
// front-to-back dump.
//
//   channel | dir | handshake      | payload
//   cmd_i   | in  | valid / ready  | command, value, position
//   res_o   | out | valid / ready  | status, entry_count, element,
//           |     |                | element_valid, last
//
// An insert or delete is taken in the idle state; the exec state then shifts
// the entry registers and loads the result register. A dump reads one entry
// per cycle from the entry register file while the result is not stalled.
// Reset clears the count; entries above the count hold anything.
// A stalled result holds the sequencer; a new transaction is still taken
// while the last result waits.
// ----------------------------------------------------------------------------
module positional_ordered_list_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  pol_cmd_if.sink     cmd_i,
  pol_res_if.source   res_o
);

  pol_pkg::dp_cmd_t  dp_cmd;
  pol_pkg::dp_stat_t dp_stat;

  pol_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_i.valid),
    .cmd_ready_o    (cmd_i.ready),
    .cmd_command_i  (cmd_i.command),
    .cmd_position_i (cmd_i.position),
    .stat_i         (dp_stat),
    .dp_o           (dp_cmd)
  );

  pol_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .stat_o           (dp_stat),
    .value_i          (cmd_i.value),
    .res_ready_i      (res_o.ready),
    .res_valid_o      (res_o.valid),
    .res_status_o     (res_o.status),
    .res_count_o      (res_o.entry_count),
    .res_element_o    (res_o.element),
    .res_elem_valid_o (res_o.element_valid),
    .res_last_o       (res_o.last)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_stat.count <= pol_pkg::CNT_W'(pol_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_i.ready |=> !cmd_i.ready)
    else $error("transaction taken while one is in progress");

  a_shift_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.op != pol_pkg::DP_NOP |-> dp_cmd.load_res && !dp_stat.res_busy)
    else $error("list changed without a result slot");

  a_element_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.element_valid |-> res_o.element == '0)
    else $error("element non-zero outside dump");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional ordered list. A short table of
// commands covers empty, full and bad-position cases and every opcode but
// delete-back. A stream of random commands follows, biased to swing the list
// between empty and full, under several patterns of sender gaps and receiver
// back-pressure. A shadow list model runs each accepted command; every result
// is checked field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import pol_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int RANDOM_PER_PHASE = 36;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    status_e                status;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic [ELEM_OUT_W-1:0]  element;
    logic                   element_valid;
    logic                   last;
  } list_res_t;

  // Typed-in expectation for a directed row; fixed set to 0 defers to the model
  typedef struct packed {
    logic                   fixed;
    status_e                status;
    logic [COUNT_OUT_W-1:0] count;
  } op_note_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
    op_note_t           note;
  } stim_row_t;

  localparam op_note_t FROM_MODEL = '{1'b0, ST_OK, 5'd0};

  localparam int DIRECTED_N = 28;
  stim_row_t directed_rows [DIRECTED_N] = '{
    '{CMD_DUMP,      32'h0000_0000, 6'd0,  '{1'b1, ST_EMPTY,   5'd0}},
    '{CMD_DEL_FRONT, 32'h0000_0000, 6'd0,  '{1'b1, ST_EMPTY,   5'd0}},
    // empty is reported ahead of the bad position
    '{CMD_DEL_AT,    32'h0000_0000, 6'd0,  '{1'b1, ST_EMPTY,   5'd0}},
    '{CMD_INS_AT,    32'hDEAD_BEEF, 6'd0,  '{1'b1, ST_BAD_POS, 5'd0}},
    '{CMD_INS_AT,    32'h0000_0000, 6'd1,  FROM_MODEL},
    '{CMD_INS_FRONT, 32'hFFFF_FFFF, 6'd0,  FROM_MODEL},
    '{CMD_INS_BACK,  32'h8000_0000, 6'd0,  FROM_MODEL},
    '{CMD_INS_AT,    32'h0000_0001, 6'd4,  FROM_MODEL},
    '{CMD_INS_AT,    32'h5555_5555, 6'd2,  FROM_MODEL},
    '{CMD_INS_FRONT, 32'hA5A5_A5A5, 6'd0,  FROM_MODEL},
    '{CMD_INS_BACK,  32'h5A5A_5A5A, 6'd0,  FROM_MODEL},
    '{CMD_INS_AT,    32'h7FFF_FFFF, 6'd7,  FROM_MODEL},
    '{CMD_INS_FRONT, 32'h0F0F_0F0F, 6'd0,  FROM_MODEL},
    '{CMD_INS_BACK,  32'hF0F0_F0F0, 6'd0,  FROM_MODEL},
    '{CMD_INS_AT,    32'h1234_5678, 6'd1,  FROM_MODEL},
    '{CMD_INS_AT,    32'h89AB_CDEF, 6'd12, FROM_MODEL},
    '{CMD_INS_BACK,  32'h00FF_00FF, 6'd0,  FROM_MODEL},
    '{CMD_INS_FRONT, 32'hFF00_FF00, 6'd0,  FROM_MODEL},
    '{CMD_INS_AT,    32'h3C3C_3C3C, 6'd8,  FROM_MODEL},
    '{CMD_INS_AT,    32'hC3C3_C3C3, 6'd16, FROM_MODEL},
    '{CMD_INS_BACK,  32'h0000_0001, 6'd0,  '{1'b1, ST_FULL,    5'd16}},
    // position is checked ahead of fullness
    '{CMD_INS_AT,    32'h0000_0002, 6'd63, '{1'b1, ST_BAD_POS, 5'd16}},
    '{CMD_INS_AT,    32'h0000_0003, 6'd17, '{1'b1, ST_FULL,    5'd16}},
    '{CMD_DUMP,      32'h0000_0000, 6'd0,  FROM_MODEL},
    '{CMD_UNUSED,    32'hFFFF_FFFF, 6'd63, '{1'b1, ST_OK,      5'd16}},
    '{CMD_DEL_AT,    32'h0000_0000, 6'd0,  '{1'b1, ST_BAD_POS, 5'd16}},
    '{CMD_DEL_AT,    32'h0000_0000, 6'd17, '{1'b1, ST_BAD_POS, 5'd16}},
    '{CMD_DEL_AT,    32'h0000_0000, 6'd16, FROM_MODEL}
  };

  int send_idle_tbl [4] = '{0, 82, 0, 25};
  int recv_stall_tbl [4] = '{0, 0, 82, 25};

  logic clk_i;
  logic rst_ni;

  pol_cmd_if cmd_if ();
  pol_res_if res_if ();

  positional_ordered_list_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  // Shadow list
  logic [DATA_WIDTH-1:0] model_words [CAPACITY];
  int unsigned           model_len;
  list_res_t             res_batch [CAPACITY];
  int unsigned           batch_n;

  list_res_t pending_results_q [$];
  op_note_t  op_note_q [$];
  int        mismatch_count;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_len;
  bit        growing;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin : watchdog
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void add_result(status_e st, logic [DATA_WIDTH-1:0] word,
                                     logic elem_valid, logic is_last);
    res_batch[batch_n] = '{st, COUNT_OUT_W'(model_len), ELEM_OUT_W'(word),
                           elem_valid, is_last};
    batch_n++;
  endfunction

  function automatic void insert_word(int unsigned idx, logic [VALUE_W-1:0] word);
    for (int unsigned i = model_len; i > idx; i--)
      model_words[i] = model_words[i-1];
    model_words[idx] = word[DATA_WIDTH-1:0];
    model_len++;
  endfunction

  function automatic void remove_word(int unsigned idx);
    for (int unsigned i = idx; i + 1 < model_len; i++)
      model_words[i] = model_words[i+1];
    model_len--;
  endfunction

  // Apply one command to the shadow list and collect the results it causes
  function automatic void predict_list_results(logic [CMD_W-1:0] cmd,
                                               logic [VALUE_W-1:0] val,
                                               logic [POS_W-1:0] pos);
    status_e     st;
    int unsigned p;
    st = ST_OK;
    p = pos;
    batch_n = 0;
    case (cmd)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        if (model_len >= CAPACITY) st = ST_FULL;
        else insert_word((cmd == CMD_INS_FRONT) ? 0 : model_len, val);
      end
      CMD_INS_AT: begin
        if (p < 1 || p > model_len + 1) st = ST_BAD_POS;
        else if (model_len >= CAPACITY) st = ST_FULL;
        else insert_word(p - 1, val);
      end
      CMD_DEL_FRONT, CMD_DEL_BACK: begin
        if (model_len == 0) st = ST_EMPTY;
        else remove_word((cmd == CMD_DEL_FRONT) ? 0 : model_len - 1);
      end
      CMD_DEL_AT: begin
        if (model_len == 0) st = ST_EMPTY;
        else if (p < 1 || p > model_len) st = ST_BAD_POS;
        else remove_word(p - 1);
      end
      CMD_DUMP: begin
        if (model_len == 0) st = ST_EMPTY;
        for (int unsigned i = 0; i < model_len; i++)
          add_result(ST_OK, model_words[i], 1'b1, i + 1 == model_len);
      end
      default: ;
    endcase
    if (batch_n == 0) add_result(st, '0, 1'b0, 1'b1);
  endfunction

  function automatic void log_fault(string what, list_res_t want, list_res_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t %s: exp st=%0d cnt=%0d el=%h ev=%b last=%b, ",
               $time, what, want.status, want.entry_count, want.element,
               want.element_valid, want.last,
               "got st=%0d cnt=%0d el=%h ev=%b last=%b",
               got.status, got.entry_count, got.element, got.element_valid,
               got.last);
  endfunction

  always @(posedge clk_i) begin : scoreboard
    list_res_t got;
    list_res_t want;
    op_note_t  note;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got = '{status_e'(res_if.status), res_if.entry_count, res_if.element,
                res_if.element_valid, res_if.last};
        if (pending_results_q.size() == 0) begin
          log_fault("unexpected result", got, got);
        end else begin
          want = pending_results_q.pop_front();
          if (got.status !== want.status || got.entry_count !== want.entry_count ||
              got.element !== want.element || got.element_valid !== want.element_valid ||
              got.last !== want.last)
            log_fault("result mismatch", want, got);
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        note = (op_note_q.size() != 0) ? op_note_q.pop_front() : FROM_MODEL;
        predict_list_results(cmd_if.command, cmd_if.value, cmd_if.position);
        if (note.fixed) begin
          pending_results_q.push_back('{note.status, note.count, '0, 1'b0, 1'b1});
        end else begin
          for (int unsigned i = 0; i < batch_n; i++)
            pending_results_q.push_back(res_batch[i]);
        end
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request
  initial begin : result_sink
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len != 0) begin
        res_if.ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic offer_cmd(logic [CMD_W-1:0] c, logic [VALUE_W-1:0] v,
                           logic [POS_W-1:0] p, op_note_t note);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    op_note_q.push_back(note);
    cmd_if.valid    <= 1'b1;
    cmd_if.command  <= c;
    cmd_if.value    <= v;
    cmd_if.position <= p;
    do @(posedge clk_i); while (!cmd_if.ready);
  endtask

  task automatic wait_results_drained();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results_q.size() != 0) @(posedge clk_i);
  endtask

  // Random command, biased to sweep the list between empty and full
  task automatic pick_random_cmd(output logic [CMD_W-1:0] c,
                                 output logic [VALUE_W-1:0] v,
                                 output logic [POS_W-1:0] p);
    int unsigned roll;
    int unsigned ins_top;
    if (model_len >= CAPACITY) growing = 1'b0;
    else if (model_len == 0) growing = 1'b1;
    ins_top = growing ? 78 : 33;
    roll = $urandom_range(99);
    v = $urandom;
    p = POS_W'($urandom_range(63));
    if (roll < 3) begin
      c = CMD_UNUSED;
    end else if (roll < 13) begin
      c = CMD_DUMP;
    end else if (roll < ins_top) begin
      case ($urandom_range(2))
        0: c = CMD_INS_FRONT;
        1: c = CMD_INS_BACK;
        default: c = CMD_INS_AT;
      endcase
      if (c == CMD_INS_AT && $urandom_range(9) < 8)
        p = POS_W'($urandom_range(model_len + 1, 1));
    end else begin
      case ($urandom_range(2))
        0: c = CMD_DEL_FRONT;
        1: c = CMD_DEL_BACK;
        default: c = CMD_DEL_AT;
      endcase
      if (c == CMD_DEL_AT && $urandom_range(9) < 8)
        p = POS_W'($urandom_range((model_len > 0) ? model_len : 1, 1));
    end
  endtask

  initial begin : stimulus
    logic [CMD_W-1:0]   c;
    logic [VALUE_W-1:0] v;
    logic [POS_W-1:0]   p;
    rst_ni          = 1'b0;
    cmd_if.valid    = 1'b0;
    cmd_if.command  = CMD_INS_FRONT;
    cmd_if.value    = '0;
    cmd_if.position = '0;
    model_len       = 0;
    mismatch_count  = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_len        = 0;
    growing         = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      offer_cmd(directed_rows[i].command, directed_rows[i].value,
                directed_rows[i].position, directed_rows[i].note);
    wait_results_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_idle_tbl[ph];
      recv_stall_pct = recv_stall_tbl[ph];
      // Starve the output while commands keep coming so the block backs up
      if (ph == 0) hold_len = HOLD_OFF_CYCLES;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick_random_cmd(c, v, p);
        offer_cmd(c, v, p, FROM_MODEL);
      end
      wait_results_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results_q.size() != 0) mismatch_count += pending_results_q.size();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== positional_ordered_list_top.f =====
hdl/pol_pkg.sv
hdl/pol_cmd_if.sv
hdl/pol_res_if.sv
hdl/pol_datapath.sv
hdl/pol_ctrl.sv
hdl/positional_ordered_list_top.sv
tb/tb_top.sv
